// File: design/pih_pkg.sv
// Package: shared types and constants of the point-in-hexahedron test.
`timescale 1ns / 1ps
package pih_pkg;

  // Corner and face counts of a hexahedron
  localparam int NUM_CORNERS  = 8;
  localparam int CORNER_IDX_W = 3;
  localparam int NUM_FACES    = 6;
  localparam int FACE_IDX_W   = 3;

  localparam logic [FACE_IDX_W-1:0] LAST_FACE = FACE_IDX_W'(NUM_FACES - 1);

  // Item mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  // Face table: corners a, b and c of each face plane
  localparam logic [CORNER_IDX_W-1:0] FACE_A [NUM_FACES] =
    '{3'd4, 3'd0, 3'd5, 3'd4, 3'd6, 3'd4};
  localparam logic [CORNER_IDX_W-1:0] FACE_B [NUM_FACES] =
    '{3'd5, 3'd2, 3'd1, 3'd6, 3'd7, 3'd0};
  localparam logic [CORNER_IDX_W-1:0] FACE_C [NUM_FACES] =
    '{3'd7, 3'd3, 3'd3, 3'd2, 3'd3, 3'd1};

  // Face sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_AB,
    S_RD_C,
    S_DIFF,
    S_MUL,
    S_NORM,
    S_DOT_LO,
    S_DOT_HI,
    S_SUM
  } pih_state_t;

endpackage

// File: design/pih_if.sv
// Interfaces: input word and result word channels with valid/ready handshake.
`timescale 1ns / 1ps
interface pih_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [2:0]                    corner_index;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic signed [COORD_WIDTH-1:0] coord_z;

  modport source (
    output valid, mode, corner_index, coord_x, coord_y, coord_z,
    input  ready
  );
  modport sink (
    input  valid, mode, corner_index, coord_x, coord_y, coord_z,
    output ready
  );
endinterface

interface pih_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (
    output valid, inside_res,
    input  ready
  );
  modport sink (
    input  valid, inside_res,
    output ready
  );
endinterface

// File: design/point_in_hexahedron_test.sv
// Top level: corner memory and face sequencer of the point-in-hexahedron test.
// A load word writes one corner and gives no result.
// A query runs the six faces in turn (corner reads, edge differences, cross product,
// normal, split dot product, sign), and stops at the first rejecting face: its result
// is registered once the output slot is free. The next word is taken once idle.
// Synchronous reset clears control and corner valid bits: unit cube, no clearing pass.
`timescale 1ns / 1ps
module point_in_hexahedron_test
  import pih_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  pih_in_if.sink     in_word,
  pih_out_if.source  out_word
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;          // edge and offset components
  localparam int PW = 2 * DW;          // cross product terms
  localparam int NW = PW + 1;          // normal components
  localparam int HW = NW - DW;         // upper slice of a normal component
  localparam int MW = DW + HW;         // dot product partial products
  localparam int AW = MW + 2;          // sum of three partial products
  localparam int SW = AW + DW;         // full dot product
  localparam int EW = 3 * CW;          // memory entry {z, y, x}

  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [NW-1:0] norm_t;
  typedef logic signed [MW-1:0] part_t;

  // Unit cube corner: bit k of the index sets coordinate k to one
  function automatic logic [EW-1:0] cube_corner(input logic [CORNER_IDX_W-1:0] idx);
    logic [CW-1:0] one;
    logic [EW-1:0] c;
    one = CW'(1) << FRAC_BITS;
    c   = '0;
    for (int k = 0; k < 3; k++) begin
      c[k*CW +: CW] = idx[k] ? one : '0;
    end
    return c;
  endfunction

  // Coordinate k of a memory entry
  function automatic logic signed [CW-1:0] coord(input logic [EW-1:0] e, input int k);
    return $signed(e[k*CW +: CW]);
  endfunction

  // Widened difference of two coordinates
  function automatic diff_t sub(input logic signed [CW-1:0] x,
                                input logic signed [CW-1:0] y);
    return DW'(x) - DW'(y);
  endfunction

  // ---------------------------------------------------------------------------
  // Control
  pih_state_t state_r, state_nxt;
  logic [FACE_IDX_W-1:0] face_r;
  logic                  out_valid_r;
  logic                  out_inside_r;

  logic in_fire;
  logic load_fire;
  logic test_fire;
  logic slot_free;
  logic reject;
  logic done;
  logic result_fire;

  // Corner memory and its valid bits
  logic [EW-1:0]           mem [NUM_CORNERS];
  logic [NUM_CORNERS-1:0]  vld_r;
  logic [CORNER_IDX_W-1:0] rd0_addr, rd1_addr;
  logic [EW-1:0]           rd0_r, rd1_r;
  logic                    rd0_vld_r, rd1_vld_r;
  logic [CORNER_IDX_W-1:0] rd0_idx_r, rd1_idx_r;
  logic [EW-1:0]           rd0_data, rd1_data;

  // Datapath registers
  logic signed [CW-1:0] q_r [3];
  logic signed [CW-1:0] a_r [3];
  diff_t                u_r [3];
  diff_t                v_r [3];
  diff_t                w_r [3];
  prod_t                p_r [6];
  norm_t                n_r [3];
  part_t                lo_r [3];
  part_t                hi_r [3];
  logic signed [SW-1:0] dot;

  assign in_fire   = in_word.valid && in_word.ready;
  assign load_fire = in_fire && (in_word.mode == MODE_LOAD);
  assign test_fire = in_fire && (in_word.mode == MODE_TEST);
  assign slot_free = !out_valid_r || out_word.ready;

  // Memory read data: an unwritten corner reads as the unit cube
  assign rd0_data = rd0_vld_r ? rd0_r : cube_corner(rd0_idx_r);
  assign rd1_data = rd1_vld_r ? rd1_r : cube_corner(rd1_idx_r);

  // Dot product: upper slice scaled by 2^DW plus lower slice
  always_comb begin
    logic signed [AW-1:0] sum_lo;
    logic signed [AW-1:0] sum_hi;
    sum_lo = AW'(lo_r[0]) + AW'(lo_r[1]) + AW'(lo_r[2]);
    sum_hi = AW'(hi_r[0]) + AW'(hi_r[1]) + AW'(hi_r[2]);
    dot    = (SW'(sum_hi) <<< DW) + SW'(sum_lo);
  end

  assign reject      = dot > 0;
  assign done        = reject || (face_r == LAST_FACE);
  assign result_fire = (state_r == S_SUM) && done && slot_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (test_fire) begin
                  state_nxt = S_RD_AB;
                end
      S_RD_AB:  state_nxt = S_RD_C;
      S_RD_C:   state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_MUL;
      S_MUL:    state_nxt = S_NORM;
      S_NORM:   state_nxt = S_DOT_LO;
      S_DOT_LO: state_nxt = S_DOT_HI;
      S_DOT_HI: state_nxt = S_SUM;
      S_SUM: begin
        if (!done) begin
          state_nxt = S_RD_AB;
        end else if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory read addresses
  always_comb begin
    in_word.ready = 1'b0;
    rd0_addr      = FACE_A[face_r];
    rd1_addr      = FACE_B[face_r];
    unique case (state_r)
      S_IDLE:  in_word.ready = 1'b1;
      S_RD_C:  rd0_addr      = FACE_C[face_r];
      default: ;
    endcase
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.inside_res = out_inside_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      face_r      <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (test_fire) begin
        face_r <= '0;
      end else if ((state_r == S_SUM) && !done) begin
        face_r <= face_r + FACE_IDX_W'(1);
      end
      if (result_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
      if (load_fire) begin
        vld_r[in_word.corner_index] <= 1'b1;
      end
    end
  end

  // Corner memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (load_fire) begin
      mem[in_word.corner_index] <= {in_word.coord_z, in_word.coord_y, in_word.coord_x};
    end
    rd0_r     <= mem[rd0_addr];
    rd1_r     <= mem[rd1_addr];
    rd0_idx_r <= rd0_addr;
    rd1_idx_r <= rd1_addr;
    rd0_vld_r <= vld_r[rd0_addr];
    rd1_vld_r <= vld_r[rd1_addr];
  end

  // Face datapath: one step per state
  always_ff @(posedge clk) begin
    if (result_fire) begin
      out_inside_r <= !reject;
    end
    if (test_fire) begin
      q_r[0] <= in_word.coord_x;
      q_r[1] <= in_word.coord_y;
      q_r[2] <= in_word.coord_z;
    end
    unique case (state_r)
      // corners a and b arrive: edge u and point offset w
      S_RD_C: begin
        for (int k = 0; k < 3; k++) begin
          a_r[k] <= coord(rd0_data, k);
          u_r[k] <= sub(coord(rd1_data, k), coord(rd0_data, k));
          w_r[k] <= sub(q_r[k], coord(rd0_data, k));
        end
      end
      // corner c arrives: edge v
      S_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          v_r[k] <= sub(coord(rd0_data, k), a_r[k]);
        end
      end
      // cross product terms
      S_MUL: begin
        p_r[0] <= u_r[1] * v_r[2];
        p_r[1] <= u_r[2] * v_r[1];
        p_r[2] <= u_r[2] * v_r[0];
        p_r[3] <= u_r[0] * v_r[2];
        p_r[4] <= u_r[0] * v_r[1];
        p_r[5] <= u_r[1] * v_r[0];
      end
      // plane normal
      S_NORM: begin
        for (int k = 0; k < 3; k++) begin
          n_r[k] <= NW'(p_r[2*k]) - NW'(p_r[2*k+1]);
        end
      end
      // dot product, lower slice of the normal (unsigned)
      S_DOT_LO: begin
        for (int k = 0; k < 3; k++) begin
          lo_r[k] <= MW'(w_r[k]) * MW'($signed({1'b0, n_r[k][DW-1:0]}));
        end
      end
      // dot product, upper slice of the normal (signed)
      S_DOT_HI: begin
        for (int k = 0; k < 3; k++) begin
          hi_r[k] <= MW'(w_r[k]) * MW'($signed(n_r[k][NW-1:DW]));
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/pih_checker.sv
// Checker: port-level properties of the point-in-hexahedron test, bound to the top level.
`timescale 1ns / 1ps
module pih_checker
  import pih_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_mode,
  input logic out_valid,
  input logic out_ready,
  input logic out_inside
);

  // Hold a stalled result word
  ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside))
    else $error("result word dropped or changed while stalled");

  // No result word right after reset
  ast_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // A load gives no result, and a query gives none in the cycle after it is taken
  ast_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result word appeared one cycle after a word was taken");

  // A query closes the input until its result is produced
  ast_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_TEST) |=> !in_ready)
    else $error("input still open while a query runs");

  // A new result comes only out of a running query
  ast_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word produced while idle");

endmodule

bind point_in_hexahedron_test pih_checker u_pih_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_word.valid),
  .in_ready   (in_word.ready),
  .in_mode    (in_word.mode),
  .out_valid  (out_word.valid),
  .out_ready  (out_word.ready),
  .out_inside (out_word.inside_res)
);
